// ===== rtl/adt_pkg.sv =====
package adt_pkg;

   // field widths
   localparam int unsigned ADDR_W          = 14;
   localparam int unsigned ENTRIES_DEFAULT = 128;

   // command codes carried in req_tuser
   typedef enum logic [1:0] {
      MODE_LOOKUP    = 2'd0,
      MODE_SET       = 2'd1,
      MODE_CLEAR     = 2'd2,
      MODE_CLEAR_ALL = 2'd3
   } mode_type;

   // direction codes
   localparam logic [1:0] DIR_NONE   = 2'd0;
   localparam logic [1:0] DIR_CLOSED = 2'd1;
   localparam logic [1:0] DIR_THROWN = 2'd2;

   // set and clear outcome codes
   localparam logic [1:0] STAT_NOCHANGE = 2'd0;
   localparam logic [1:0] STAT_DONE     = 2'd1;
   localparam logic [1:0] STAT_FULL     = 2'd2;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EVAL,
      ST_WRITE,
      ST_DONE
   } state_type;

   // one table slot, address zero means free
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic              thrown;
   } slot_type;

   // controls broadcast to every cell
   typedef struct packed {
      logic shift;
      logic clear_all;
   } ctl_type;

   function automatic logic [1:0] dir_code(input logic thrown);
      return thrown ? DIR_THROWN : DIR_CLOSED;
   endfunction

endpackage

// ===== rtl/adt_cell.sv =====
module adt_cell (
   input  logic              clock,
   input  logic              reset,
   input  adt_pkg::ctl_type  ctl,
   input  adt_pkg::slot_type slot_in,
   output adt_pkg::slot_type slot_out
);

   adt_pkg::slot_type slot_ff;
   adt_pkg::slot_type slot_in_d;

   // take the neighbor's slot on a shift, empty on clear
   always_comb begin
      slot_in_d = slot_ff;
      if (ctl.clear_all) begin
         slot_in_d = '0;
      end else if (ctl.shift) begin
         slot_in_d = slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in_d;
      end
   end

   assign slot_out = slot_ff;

endmodule

// ===== rtl/adt_ctrl.sv =====
module adt_ctrl #(
   parameter int unsigned ENTRIES = adt_pkg::ENTRIES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   // command beat
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [15:0]       req_tdata,   // [13:0] vehicle_address, [14] set_thrown
   input  logic [1:0]        req_tuser,   // [1:0] mode
   // result beat
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // [0] registered, [2:1] direction, [4:3] status
   // ring head
   input  adt_pkg::slot_type head_in,
   output adt_pkg::slot_type head_out,
   output adt_pkg::ctl_type  ctl
);

   localparam int unsigned IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   adt_pkg::state_type state_ff, state_in;
   adt_pkg::mode_type  mode_ff, mode_in;
   logic [adt_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic thr_ff, thr_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic found_ff, found_in;
   logic fthr_ff, fthr_in;
   logic changed_ff, changed_in;
   logic free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_pos_ff, free_pos_in;
   logic def_en_ff, def_en_in;
   logic def_thr_ff, def_thr_in;
   logic res_reg_ff, res_reg_in;
   logic [1:0] res_dir_ff, res_dir_in;
   logic [1:0] res_st_ff, res_st_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;

   logic req_accept;
   logic out_free;
   logic cnt_last;
   logic hit;
   logic is_free;
   adt_pkg::mode_type req_mode;
   logic [adt_pkg::ADDR_W-1:0] req_addr;

   assign req_mode   = adt_pkg::mode_type'(req_tuser);
   assign req_addr   = req_tdata[adt_pkg::ADDR_W-1:0];
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign cnt_last   = (cnt_ff == LAST_IDX);
   assign hit        = (head_in.addr == addr_ff);
   assign is_free    = (head_in.addr == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         adt_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_mode == adt_pkg::MODE_CLEAR_ALL || req_addr == '0) begin
                  state_in = adt_pkg::ST_DONE;
               end else begin
                  state_in = adt_pkg::ST_SCAN;
               end
            end
         end
         adt_pkg::ST_SCAN: begin
            if (cnt_last) begin
               state_in = adt_pkg::ST_EVAL;
            end
         end
         adt_pkg::ST_EVAL: begin
            if (mode_ff == adt_pkg::MODE_SET && !found_ff && free_found_ff) begin
               state_in = adt_pkg::ST_WRITE;
            end else begin
               state_in = adt_pkg::ST_DONE;
            end
         end
         adt_pkg::ST_WRITE: begin
            if (cnt_last) begin
               state_in = adt_pkg::ST_DONE;
            end
         end
         adt_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = adt_pkg::ST_IDLE;
            end
         end
         default: state_in = adt_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_tready    = (state_ff == adt_pkg::ST_IDLE);
      ctl           = '0;
      head_out      = head_in;
      mode_in       = mode_ff;
      addr_in       = addr_ff;
      thr_in        = thr_ff;
      cnt_in        = cnt_ff;
      found_in      = found_ff;
      fthr_in       = fthr_ff;
      changed_in    = changed_ff;
      free_found_in = free_found_ff;
      free_pos_in   = free_pos_ff;
      def_en_in     = def_en_ff;
      def_thr_in    = def_thr_ff;
      res_reg_in    = res_reg_ff;
      res_dir_in    = res_dir_ff;
      res_st_in     = res_st_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         adt_pkg::ST_IDLE: begin
            if (req_accept) begin
               mode_in       = req_mode;
               addr_in       = req_addr;
               thr_in        = req_tdata[adt_pkg::ADDR_W];
               cnt_in        = '0;
               found_in      = 1'b0;
               fthr_in       = 1'b0;
               changed_in    = 1'b0;
               free_found_in = 1'b0;
               free_pos_in   = '0;
               res_reg_in    = 1'b0;
               res_dir_in    = adt_pkg::DIR_NONE;
               res_st_in     = adt_pkg::STAT_NOCHANGE;
               if (req_mode == adt_pkg::MODE_CLEAR_ALL) begin
                  ctl.clear_all = 1'b1;
                  def_en_in     = 1'b0;
                  def_thr_in    = 1'b0;
                  res_st_in     = adt_pkg::STAT_DONE;
               end else if (req_addr == '0) begin
                  // default rule commands
                  case (req_mode)
                     adt_pkg::MODE_LOOKUP: begin
                        res_reg_in = def_en_ff;
                        res_dir_in = def_en_ff ? adt_pkg::dir_code(def_thr_ff)
                                               : adt_pkg::DIR_NONE;
                     end
                     adt_pkg::MODE_SET: begin
                        if (!(def_en_ff && def_thr_ff == req_tdata[adt_pkg::ADDR_W])) begin
                           res_st_in = adt_pkg::STAT_DONE;
                        end
                        def_en_in  = 1'b1;
                        def_thr_in = req_tdata[adt_pkg::ADDR_W];
                     end
                     adt_pkg::MODE_CLEAR: begin
                        if (def_en_ff || def_thr_ff) begin
                           res_st_in = adt_pkg::STAT_DONE;
                        end
                        def_en_in  = 1'b0;
                        def_thr_in = 1'b0;
                     end
                     default: ;
                  endcase
               end
            end
         end
         adt_pkg::ST_SCAN: begin
            // one slot reaches the head per cycle, in slot order
            ctl.shift = 1'b1;
            cnt_in    = cnt_ff + IDX_W'(1);
            case (mode_ff)
               adt_pkg::MODE_LOOKUP: begin
                  if (hit && !found_ff) begin
                     found_in = 1'b1;
                     fthr_in  = head_in.thrown;
                  end
               end
               adt_pkg::MODE_SET: begin
                  if (hit && !found_ff) begin
                     found_in = 1'b1;
                     if (head_in.thrown != thr_ff) begin
                        head_out.thrown = thr_ff;
                        changed_in      = 1'b1;
                     end
                  end
                  if (is_free && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_pos_in   = cnt_ff;
                  end
               end
               adt_pkg::MODE_CLEAR: begin
                  if (hit) begin
                     head_out   = '0;
                     changed_in = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         adt_pkg::ST_EVAL: begin
            cnt_in = '0;
            case (mode_ff)
               adt_pkg::MODE_LOOKUP: begin
                  if (found_ff) begin
                     res_reg_in = 1'b1;
                     res_dir_in = adt_pkg::dir_code(fthr_ff);
                  end else begin
                     res_reg_in = 1'b0;
                     res_dir_in = def_en_ff ? adt_pkg::dir_code(def_thr_ff)
                                            : adt_pkg::DIR_NONE;
                  end
               end
               adt_pkg::MODE_SET: begin
                  if (found_ff) begin
                     res_st_in = changed_ff ? adt_pkg::STAT_DONE : adt_pkg::STAT_NOCHANGE;
                  end else if (free_found_ff) begin
                     res_st_in = adt_pkg::STAT_DONE;
                  end else begin
                     res_st_in = adt_pkg::STAT_FULL;
                  end
               end
               adt_pkg::MODE_CLEAR: begin
                  res_st_in = changed_ff ? adt_pkg::STAT_DONE : adt_pkg::STAT_NOCHANGE;
               end
               default: ;
            endcase
         end
         adt_pkg::ST_WRITE: begin
            // second lap drops the new entry into the first free slot
            ctl.shift = 1'b1;
            cnt_in    = cnt_ff + IDX_W'(1);
            if (cnt_ff == free_pos_ff) begin
               head_out.addr   = addr_ff;
               head_out.thrown = thr_ff;
            end
         end
         adt_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, res_st_ff, res_dir_ff, res_reg_ff};
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= adt_pkg::ST_IDLE;
         def_en_ff    <= 1'b0;
         def_thr_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         def_en_ff    <= def_en_in;
         def_thr_ff   <= def_thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // per-command working registers
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      addr_ff       <= addr_in;
      thr_ff        <= thr_in;
      cnt_ff        <= cnt_in;
      found_ff      <= found_in;
      fthr_ff       <= fthr_in;
      changed_ff    <= changed_in;
      free_found_ff <= free_found_in;
      free_pos_ff   <= free_pos_in;
      res_reg_ff    <= res_reg_in;
      res_dir_ff    <= res_dir_in;
      res_st_ff     <= res_st_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // default direction is only kept while the default is enabled
   a_def_thr_en: assert property (@(posedge clock) disable iff (reset)
      def_thr_ff |-> def_en_ff)
      else $error("default direction set while default disabled");

   // clear-all leaves the default disabled
   a_clear_all_def: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_mode == adt_pkg::MODE_CLEAR_ALL) |=> !def_en_ff)
      else $error("default still enabled after clear-all");

   // a new result beat is only loaded from the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == adt_pkg::ST_DONE))
      else $error("result beat appeared outside the done state");

   // a table lap always starts at slot zero
   a_lap_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == adt_pkg::ST_SCAN && $past(state_ff) == adt_pkg::ST_IDLE)
         |-> cnt_ff == '0)
      else $error("scan started away from slot zero");

   // lookups never report a set or clear outcome
   a_lookup_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[0]) |-> rsp_data_ff[4:3] == adt_pkg::STAT_NOCHANGE)
      else $error("lookup result carries a nonzero status");

endmodule

// ===== rtl/address_direction_table_top.sv =====
// address direction table
// Keeps up to ENTRIES nonzero 14-bit vehicle addresses, each with a closed or
// thrown direction, plus a default rule. Commands arrive on the req_ channel:
// req_tuser carries the mode (lookup, set, clear, clear whole table), req_tdata
// the address and the direction to set. Each command gives one result beat on
// the rsp_ channel with the registered flag, the direction and the status.
// The slots sit in a ring of cells that, while a command scans or writes,
// rotates one slot past a single compare point at the head per cycle.
// A command on a nonzero address scans one lap of the table, then evaluates;
// a set that takes a new slot makes a second lap to write it. Commands on
// address zero and clear-all skip the laps and go straight to the result.
// One command is in work at a time; the next is accepted once the result has
// moved to the output register. A stalled receiver holds the result there;
// a next command is still accepted, but its result waits until the held one goes.
// Reset empties every slot and disables the default rule.
module address_direction_table_top #(
   parameter int unsigned ENTRIES = adt_pkg::ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [13:0] vehicle_address, [14] set_thrown
   input  logic [1:0]  req_tuser,   // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] registered, [2:1] direction, [4:3] status
);

   adt_pkg::slot_type ring [ENTRIES];
   adt_pkg::slot_type head_out;
   adt_pkg::ctl_type  ctl;

   // command sequencer with the compare point at the ring head
   adt_ctrl #(
      .ENTRIES (ENTRIES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .head_in    (ring[0]),
      .head_out   (head_out),
      .ctl        (ctl)
   );

   // ring of slot cells, each takes its upper neighbor, the last takes the head
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      if (i == ENTRIES - 1) begin : g_tail
         adt_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (ctl),
            .slot_in  (head_out),
            .slot_out (ring[i])
         );
      end else begin : g_body
         adt_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (ctl),
            .slot_in  (ring[i+1]),
            .slot_out (ring[i])
         );
      end
   end

endmodule
